// File: hw/rtl/ahv_pkg.sv
// Shared types, constants and register codes for the header and hash validator.
// Used by every module under hw/rtl; depends on nothing else.
package ahv_pkg;

  // Header layout, all byte positions counted from the start of the image.
  localparam int HEADER_BYTES = 24;
  localparam int SIG_END      = 8;
  localparam int FIELD_END    = 16;
  localparam int LEN_END      = 20;

  localparam int COUNT_W     = 33;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // FNV-1a constants.
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Register reset values.
  localparam logic [63:0] SIGNATURE_RESET  = 64'h4149444F504B4E49;
  localparam logic [15:0] VERSION_RESET    = 16'd1;
  localparam logic [15:0] WIDTH_RESET      = 16'd48;
  localparam logic [15:0] HEIGHT_RESET     = 16'd48;
  localparam logic [15:0] ICON_COUNT_RESET = 16'd32;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIGNATURE  = 3'd0,
    REG_VERSION    = 3'd1,
    REG_WIDTH      = 3'd2,
    REG_HEIGHT     = 3'd3,
    REG_ICON_COUNT = 3'd4
  } reg_index_t;

  // Result status codes, in the order the checks are applied.
  typedef enum logic [3:0] {
    STATUS_OK        = 4'd0,
    STATUS_SHORT     = 4'd1,
    STATUS_SIGNATURE = 4'd2,
    STATUS_VERSION   = 4'd3,
    STATUS_WIDTH     = 4'd4,
    STATUS_HEIGHT    = 4'd5,
    STATUS_COUNT     = 4'd6,
    STATUS_SIZE      = 4'd7,
    STATUS_HASH      = 4'd8
  } status_t;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] computed_hash;
  } out_item_t;

  // Current register contents.
  typedef struct packed {
    logic [63:0] signature;
    logic [15:0] version;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] icon_count;
  } cfg_t;

  // Everything the final checks need about one finished image.
  typedef struct packed {
    logic [COUNT_W-1:0] total;
    logic [31:0]        declared_length;
    logic [31:0]        declared_hash;
    logic [31:0]        hash;
    status_t            first_error;
  } summary_t;

endpackage

// File: hw/rtl/ahv_cfg_regs.sv
// Configuration registers and the registered width times height product.
// Depends on ahv_pkg.
module ahv_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ahv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ahv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ahv_pkg::cfg_t                   cfg,
  output logic [31:0]                     area
);

  // Register file; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signature  <= ahv_pkg::SIGNATURE_RESET;
      cfg.version    <= ahv_pkg::VERSION_RESET;
      cfg.width      <= ahv_pkg::WIDTH_RESET;
      cfg.height     <= ahv_pkg::HEIGHT_RESET;
      cfg.icon_count <= ahv_pkg::ICON_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ahv_pkg::REG_SIGNATURE:  cfg.signature  <= cfg_data;
        ahv_pkg::REG_VERSION:    cfg.version    <= cfg_data[15:0];
        ahv_pkg::REG_WIDTH:      cfg.width      <= cfg_data[15:0];
        ahv_pkg::REG_HEIGHT:     cfg.height     <= cfg_data[15:0];
        ahv_pkg::REG_ICON_COUNT: cfg.icon_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pixels per icon, registered from the width and height registers.
  always_ff @(posedge clk) begin
    area <= 32'(cfg.width) * 32'(cfg.height);
  end

endmodule

// File: hw/rtl/ahv_frame.sv
// Input register and per-image state: header checks, field capture, FNV-1a.
// Hands a summary of each finished image to the result stage. Depends on ahv_pkg.
module ahv_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  ahv_pkg::in_item_t byte_item,
  input  ahv_pkg::cfg_t     cfg,
  input  logic              summary_take,
  output logic              summary_valid,
  output ahv_pkg::summary_t summary
);

  logic                         s0_valid;
  ahv_pkg::in_item_t            s0_item;
  logic                         s0_fire;

  logic [ahv_pkg::COUNT_W-1:0]  byte_counter;
  logic [31:0]                  running_hash;
  ahv_pkg::status_t             first_error;
  logic [7:0]                   field_shift;
  logic [31:0]                  declared_payload_length;
  logic [31:0]                  declared_hash;

  logic [ahv_pkg::COUNT_W-1:0]  byte_counter_next;
  logic [31:0]                  running_hash_next;
  ahv_pkg::status_t             first_error_next;
  logic [31:0]                  declared_payload_length_next;
  logic [31:0]                  declared_hash_next;

  logic [ahv_pkg::COUNT_W-1:0]  pos;
  logic [7:0]                   b;
  logic [7:0]                   sig_byte;
  logic [15:0]                  field_value;
  logic [15:0]                  field_want;
  ahv_pkg::status_t             field_code;
  ahv_pkg::status_t             err_code;
  logic                         in_sig;
  logic                         in_field;
  logic                         in_len;
  logic                         in_dhash;
  logic                         in_payload;

  // The input stage moves on unless a final byte waits for a full summary slot.
  assign s0_fire    = s0_valid &&
                      (!s0_item.last_byte || !summary_valid || summary_take);
  assign byte_ready = !s0_valid || s0_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (byte_ready) begin
      s0_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s0_item <= byte_item;
    end
  end

  // Decode where the current byte sits in the image.
  assign pos        = byte_counter;
  assign b          = s0_item.data_byte;
  assign in_sig     = pos < ahv_pkg::COUNT_W'(ahv_pkg::SIG_END);
  assign in_field   = !in_sig && (pos < ahv_pkg::COUNT_W'(ahv_pkg::FIELD_END));
  assign in_len     = (pos >= ahv_pkg::COUNT_W'(ahv_pkg::FIELD_END)) &&
                      (pos < ahv_pkg::COUNT_W'(ahv_pkg::LEN_END));
  assign in_dhash   = (pos >= ahv_pkg::COUNT_W'(ahv_pkg::LEN_END)) &&
                      (pos < ahv_pkg::COUNT_W'(ahv_pkg::HEADER_BYTES));
  assign in_payload = pos >= ahv_pkg::COUNT_W'(ahv_pkg::HEADER_BYTES);

  assign sig_byte    = 8'(cfg.signature >> {pos[2:0], 3'b000});
  assign field_value = {b, field_shift};

  // Pick the register that the 16-bit header field at this position must match.
  always_comb begin
    case (pos[2:1])
      2'd0: begin
        field_want = cfg.version;
        field_code = ahv_pkg::STATUS_VERSION;
      end
      2'd1: begin
        field_want = cfg.width;
        field_code = ahv_pkg::STATUS_WIDTH;
      end
      2'd2: begin
        field_want = cfg.height;
        field_code = ahv_pkg::STATUS_HEIGHT;
      end
      default: begin
        field_want = cfg.icon_count;
        field_code = ahv_pkg::STATUS_COUNT;
      end
    endcase
  end

  // Header check outcome for this byte.
  always_comb begin
    err_code = ahv_pkg::STATUS_OK;
    if (in_sig && (b != sig_byte)) begin
      err_code = ahv_pkg::STATUS_SIGNATURE;
    end else if (in_field && pos[0] && (field_value != field_want)) begin
      err_code = field_code;
    end
  end

  // Next values of the image state.
  always_comb begin
    byte_counter_next            = (byte_counter == ahv_pkg::COUNT_MAX) ?
                                   byte_counter : byte_counter + 1'b1;
    first_error_next             = first_error;
    declared_payload_length_next = declared_payload_length;
    declared_hash_next           = declared_hash;
    running_hash_next            = running_hash;
    if (first_error == ahv_pkg::STATUS_OK) begin
      first_error_next = err_code;
    end
    if (in_len) begin
      declared_payload_length_next[{pos[1:0], 3'b000} +: 8] = b;
    end
    if (in_dhash) begin
      declared_hash_next[{pos[1:0], 3'b000} +: 8] = b;
    end
    if (in_payload) begin
      running_hash_next = 32'((running_hash ^ {24'd0, b}) * ahv_pkg::FNV_PRIME);
    end
  end

  // Image state; cleared after the final byte for the next image.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter            <= '0;
      running_hash            <= ahv_pkg::FNV_BASIS;
      first_error             <= ahv_pkg::STATUS_OK;
      field_shift             <= '0;
      declared_payload_length <= '0;
      declared_hash           <= '0;
    end else if (s0_fire) begin
      if (s0_item.last_byte) begin
        byte_counter            <= '0;
        running_hash            <= ahv_pkg::FNV_BASIS;
        first_error             <= ahv_pkg::STATUS_OK;
        field_shift             <= '0;
        declared_payload_length <= '0;
        declared_hash           <= '0;
      end else begin
        byte_counter            <= byte_counter_next;
        running_hash            <= running_hash_next;
        first_error             <= first_error_next;
        declared_payload_length <= declared_payload_length_next;
        declared_hash           <= declared_hash_next;
        if (in_field && !pos[0]) begin
          field_shift <= b;
        end
      end
    end
  end

  // Summary slot between the image state and the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      summary_valid <= 1'b0;
    end else if (s0_fire && s0_item.last_byte) begin
      summary_valid <= 1'b1;
    end else if (summary_take) begin
      summary_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && s0_item.last_byte) begin
      summary.total           <= byte_counter_next;
      summary.declared_length <= declared_payload_length_next;
      summary.declared_hash   <= declared_hash_next;
      summary.hash            <= running_hash_next;
      summary.first_error     <= first_error_next;
    end
  end

endmodule

// File: hw/rtl/ahv_result.sv
// Final checks on a finished image (short, size, length, hash) and the result register.
// Depends on ahv_pkg.
module ahv_result (
  input  logic               clk,
  input  logic               rst,
  input  logic               summary_valid,
  input  ahv_pkg::summary_t  summary,
  output logic               summary_take,
  input  logic [31:0]        area,
  input  logic [15:0]        icon_count,
  output logic               result_valid,
  input  logic               result_ready,
  output ahv_pkg::out_item_t result_item
);

  logic [47:0]                 size_expect;
  logic [ahv_pkg::COUNT_W-1:0] size_need;
  ahv_pkg::status_t            status;

  assign summary_take = summary_valid && (!result_valid || result_ready);

  // Expected payload size, and the total byte count the declared length implies.
  assign size_expect = 48'(area) * 48'(icon_count);
  assign size_need   = {1'b0, summary.declared_length} +
                       ahv_pkg::COUNT_W'(ahv_pkg::HEADER_BYTES);

  // First failing check wins.
  always_comb begin
    if (summary.total < ahv_pkg::COUNT_W'(ahv_pkg::HEADER_BYTES)) begin
      status = ahv_pkg::STATUS_SHORT;
    end else if (summary.first_error != ahv_pkg::STATUS_OK) begin
      status = summary.first_error;
    end else if ((size_need != summary.total) ||
                 ({16'd0, summary.declared_length} != size_expect)) begin
      status = ahv_pkg::STATUS_SIZE;
    end else if (summary.hash != summary.declared_hash) begin
      status = ahv_pkg::STATUS_HASH;
    end else begin
      status = ahv_pkg::STATUS_OK;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (summary_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (summary_take) begin
      result_item.status        <= status;
      result_item.computed_hash <= summary.hash;
    end
  end

endmodule

// File: hw/rtl/atlas_header_hash_validator.sv
// Top level of the resource image header and hash validator.
// Depends on ahv_pkg, ahv_cfg_regs, ahv_frame and ahv_result.
//
//   Channel  Dir  Handshake              Payload
//   byte     in   byte_valid/byte_ready  byte_item: data_byte, last_byte
//   result   out  result_valid/ready     result_item: status, computed_hash
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// One byte is taken every cycle unless a final byte waits for a full summary
// slot; the FNV-1a step and the header compares sit between the input
// register and the image state registers. A result is built as its final byte
// passes the input, summary and result registers in line.
// Reset restores the register values and starts a new image.
// A waiting result stalls nothing until both the result register and the
// summary slot are full and another final byte arrives.
module atlas_header_hash_validator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  ahv_pkg::in_item_t               byte_item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output ahv_pkg::out_item_t              result_item,
  input  logic                            cfg_we,
  input  logic [ahv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ahv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ahv_pkg::cfg_t     cfg;
  logic [31:0]       area;
  logic              summary_valid;
  logic              summary_take;
  ahv_pkg::summary_t summary;

  ahv_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .area      (area)
  );

  ahv_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .byte_item     (byte_item),
    .cfg           (cfg),
    .summary_take  (summary_take),
    .summary_valid (summary_valid),
    .summary       (summary)
  );

  ahv_result u_result (
    .clk           (clk),
    .rst           (rst),
    .summary_valid (summary_valid),
    .summary       (summary),
    .summary_take  (summary_take),
    .area          (area),
    .icon_count    (cfg.icon_count),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_item   (result_item)
  );

  // Input only stalls when both downstream slots are occupied.
  assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> (summary_valid && result_valid))
    else $error("byte channel stalled with a free downstream slot");

  // A new result must come from a pending summary.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(summary_valid))
    else $error("result appeared without a summary");

  // A summary is held while the result register is blocked.
  assert property (@(posedge clk) disable iff (rst)
    (summary_valid && result_valid && !result_ready) |=> summary_valid)
    else $error("summary lost while result was stalled");

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the resource image header and hash validator.
// Depends on ahv_pkg and atlas_header_hash_validator; a scoreboard class predicts each status.
module testbench;

  localparam int TOTAL_ITEMS = 720;  // input bytes after which no new phase starts
  localparam int TAIL_START  = 560;  // no idling in phases started from here on
  localparam int LONG_HOLD   = 200;  // receiver hold-off under pressure, in cycles
  localparam int DRAIN_GAP   = 8;    // cycles allowed for the pipeline to empty
  localparam int MAX_REPORTS = 10;
  localparam int MAX_PAYLOAD = 40;   // cap on payload bytes per image, before extent damage adds one
  localparam int PRESSURE_PHASE = 1;

  // Image kinds the generator can build.
  localparam int KIND_SHORT  = 0;
  localparam int KIND_NOISE  = 1;
  localparam int KIND_SIG    = 2;
  localparam int KIND_FIELD  = 3;
  localparam int KIND_LEN    = 4;
  localparam int KIND_EXTENT = 5;
  localparam int KIND_HASH   = 6;
  localparam int KIND_TRUNC  = 7;
  localparam int KIND_MULTI  = 8;
  localparam int KIND_CLEAN  = 9;

  // Predicts the status of each image and checks results in order.
  class image_scoreboard;
    ahv_pkg::cfg_t               cfg;
    logic [ahv_pkg::COUNT_W-1:0] byte_count;
    logic [31:0]                 hash_acc;
    logic [31:0]                 len_field;
    logic [31:0]                 hash_field;
    logic [7:0]                  low_half;
    ahv_pkg::status_t            first_err;
    ahv_pkg::out_item_t          expected_q[$];
    int                          mismatches;

    function new();
      cfg.signature  = ahv_pkg::SIGNATURE_RESET;
      cfg.version    = ahv_pkg::VERSION_RESET;
      cfg.width      = ahv_pkg::WIDTH_RESET;
      cfg.height     = ahv_pkg::HEIGHT_RESET;
      cfg.icon_count = ahv_pkg::ICON_COUNT_RESET;
      mismatches     = 0;
      clear_image();
    endfunction

    function void clear_image();
      byte_count = '0;
      hash_acc   = ahv_pkg::FNV_BASIS;
      len_field  = '0;
      hash_field = '0;
      low_half   = '0;
      first_err  = ahv_pkg::STATUS_OK;
    endfunction

    function logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
      return (h ^ {24'd0, b}) * ahv_pkg::FNV_PRIME;
    endfunction

    function void write_reg(logic [ahv_pkg::CFG_INDEX_W-1:0] idx,
                            logic [ahv_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ahv_pkg::REG_SIGNATURE:  cfg.signature  = val;
        ahv_pkg::REG_VERSION:    cfg.version    = val[15:0];
        ahv_pkg::REG_WIDTH:      cfg.width      = val[15:0];
        ahv_pkg::REG_HEIGHT:     cfg.height     = val[15:0];
        ahv_pkg::REG_ICON_COUNT: cfg.icon_count = val[15:0];
        default: ;
      endcase
    endfunction

    function void flag(ahv_pkg::status_t code);
      if (first_err == ahv_pkg::STATUS_OK) begin
        first_err = code;
      end
    endfunction

    // Folds one accepted input transaction into the image state.
    function void note_byte(ahv_pkg::in_item_t it);
      int unsigned        pos;
      logic [15:0]        word;
      logic [15:0]        want;
      ahv_pkg::status_t   code;
      ahv_pkg::status_t   verdict;
      logic [63:0]        product;
      logic [63:0]        need;
      ahv_pkg::out_item_t res;
      if (byte_count < ahv_pkg::HEADER_BYTES) begin
        pos = byte_count[4:0];
        if (pos < ahv_pkg::SIG_END) begin
          if (it.data_byte != cfg.signature[pos*8 +: 8]) begin
            flag(ahv_pkg::STATUS_SIGNATURE);
          end
        end else if (pos < ahv_pkg::FIELD_END) begin
          if (pos % 2 == 0) begin
            low_half = it.data_byte;
          end else begin
            word = {it.data_byte, low_half};
            case ((pos - ahv_pkg::SIG_END) / 2)
              0: begin
                want = cfg.version;
                code = ahv_pkg::STATUS_VERSION;
              end
              1: begin
                want = cfg.width;
                code = ahv_pkg::STATUS_WIDTH;
              end
              2: begin
                want = cfg.height;
                code = ahv_pkg::STATUS_HEIGHT;
              end
              default: begin
                want = cfg.icon_count;
                code = ahv_pkg::STATUS_COUNT;
              end
            endcase
            if (word != want) begin
              flag(code);
            end
          end
        end else if (pos < ahv_pkg::LEN_END) begin
          len_field[(pos - ahv_pkg::FIELD_END)*8 +: 8] = it.data_byte;
        end else begin
          hash_field[(pos - ahv_pkg::LEN_END)*8 +: 8] = it.data_byte;
        end
      end else begin
        hash_acc = fnv_step(hash_acc, it.data_byte);
      end
      if (byte_count != ahv_pkg::COUNT_MAX) begin
        byte_count = byte_count + 1'b1;
      end
      if (it.last_byte) begin
        product = 64'(cfg.icon_count) * 64'(cfg.width) * 64'(cfg.height);
        need    = 64'(ahv_pkg::HEADER_BYTES) + 64'(len_field);
        if (byte_count < ahv_pkg::HEADER_BYTES) begin
          verdict = ahv_pkg::STATUS_SHORT;
        end else if (first_err != ahv_pkg::STATUS_OK) begin
          verdict = first_err;
        end else if (need != 64'(byte_count) || 64'(len_field) != product) begin
          verdict = ahv_pkg::STATUS_SIZE;
        end else if (hash_acc != hash_field) begin
          verdict = ahv_pkg::STATUS_HASH;
        end else begin
          verdict = ahv_pkg::STATUS_OK;
        end
        res.status        = verdict;
        res.computed_hash = hash_acc;
        expected_q.push_back(res);
        clear_image();
      end
    endfunction

    // Compares one accepted result transaction with the oldest prediction.
    function void check_result(ahv_pkg::out_item_t got);
      ahv_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: status %0d hash %08h", got.status, got.computed_hash);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("status wrong: expected %0d, got %0d", want.status, got.status);
        end
      end
      if (got.computed_hash !== want.computed_hash) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("hash wrong: expected %08h, got %08h",
                   want.computed_hash, got.computed_hash);
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            byte_valid;
  logic                            byte_ready;
  ahv_pkg::in_item_t               byte_item;
  logic                            result_valid;
  logic                            result_ready;
  ahv_pkg::out_item_t              result_item;
  logic                            cfg_we;
  logic [ahv_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ahv_pkg::CFG_DATA_W-1:0]  cfg_data;

  image_scoreboard sb = new();
  logic [7:0]      image_q[$];
  int              items_sent;
  int              hold_requests;
  logic            tx_idle_on;
  logic            rx_idle_on;

  atlas_header_hash_validator dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item(result_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int served;
    hold_left    = 0;
    served       = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 17);
      end
      if (hold_left > 0) begin
        result_ready = 1'b0;
        hold_left--;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // Check every result transaction as it is accepted.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result(result_item);
    end
  end

  // Config writes happen only while the block is idle; called at a falling edge.
  task automatic write_reg(input logic [ahv_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ahv_pkg::CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Places a 16-bit value under random upper bits, which the block must drop.
  function automatic logic [ahv_pkg::CFG_DATA_W-1:0] with_junk(logic [15:0] f);
    logic [ahv_pkg::CFG_DATA_W-1:0] v;
    v       = {$urandom, $urandom};
    v[15:0] = f;
    return v;
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  // Sets all registers for one phase: all ones, all zeros, then random mixes.
  task automatic configure_phase(input int p);
    logic [63:0] sig;
    logic [15:0] ver;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] c;
    if (p == 0) begin
      sig = '1;
      ver = '1;
      w   = '1;
      h   = '1;
      c   = '1;
    end else if (p == 1) begin
      sig = '0;
      ver = '0;
      w   = '0;
      h   = '0;
      c   = '0;
    end else begin
      case ($urandom_range(0, 3))
        0: sig = '0;
        1: sig = '1;
        default: sig = {$urandom, $urandom};
      endcase
      ver = pick_dim();
      w   = pick_dim();
      h   = pick_dim();
      c   = pick_dim();
    end
    write_reg(ahv_pkg::REG_SIGNATURE, sig);
    write_reg(ahv_pkg::REG_VERSION, with_junk(ver));
    write_reg(ahv_pkg::REG_WIDTH, with_junk(w));
    write_reg(ahv_pkg::REG_HEIGHT, with_junk(h));
    write_reg(ahv_pkg::REG_ICON_COUNT, with_junk(c));
    if ($urandom_range(0, 2) == 0) begin
      write_reg(ahv_pkg::CFG_INDEX_W'($urandom_range(ahv_pkg::REG_ICON_COUNT + 1,
                                                     (1 << ahv_pkg::CFG_INDEX_W) - 1)),
                {$urandom, $urandom});
    end
  endtask

  // Builds one image in image_q, matching the current registers unless damaged.
  function automatic void build_image(input int kind);
    logic [63:0] product;
    logic [31:0] plen;
    logic [31:0] h;
    logic [7:0]  payload[$];
    logic [15:0] fields[4];
    int          n;
    int          k;
    image_q.delete();
    if (kind == KIND_SHORT || kind == KIND_NOISE) begin
      n = (kind == KIND_SHORT) ? $urandom_range(1, ahv_pkg::HEADER_BYTES - 1) :
                                 $urandom_range(1, 48);
      repeat (n) image_q.push_back(8'($urandom));
      return;
    end
    fields[0] = sb.cfg.version;
    fields[1] = sb.cfg.width;
    fields[2] = sb.cfg.height;
    fields[3] = sb.cfg.icon_count;
    product   = 64'(sb.cfg.icon_count) * 64'(sb.cfg.width) * 64'(sb.cfg.height);
    plen      = product[31:0];
    n         = (product > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(product);
    repeat (n) payload.push_back(8'($urandom));
    if (kind == KIND_EXTENT) begin
      if (payload.size() > 0 && $urandom_range(0, 1) == 0) begin
        void'(payload.pop_back());
      end else begin
        payload.push_back(8'($urandom));
      end
    end
    if (kind == KIND_LEN) begin
      plen = plen ^ (32'd1 << $urandom_range(0, 31));
    end
    h = ahv_pkg::FNV_BASIS;
    foreach (payload[i]) h = sb.fnv_step(h, payload[i]);
    if (kind == KIND_HASH || kind == KIND_MULTI) begin
      h = h ^ (32'd1 << $urandom_range(0, 31));
    end
    for (k = 0; k < ahv_pkg::SIG_END; k++) image_q.push_back(sb.cfg.signature[k*8 +: 8]);
    for (k = 0; k < 4; k++) begin
      image_q.push_back(fields[k][7:0]);
      image_q.push_back(fields[k][15:8]);
    end
    for (k = 0; k < 4; k++) image_q.push_back(plen[k*8 +: 8]);
    for (k = 0; k < 4; k++) image_q.push_back(h[k*8 +: 8]);
    foreach (payload[i]) image_q.push_back(payload[i]);
    // Header damage: a single flipped bit in the signature, in a 16-bit field, or in both.
    if (kind == KIND_SIG || kind == KIND_MULTI) begin
      k = $urandom_range(0, ahv_pkg::SIG_END - 1);
      image_q[k] = image_q[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (kind == KIND_FIELD || kind == KIND_MULTI) begin
      k = $urandom_range(ahv_pkg::SIG_END, ahv_pkg::FIELD_END - 1);
      image_q[k] = image_q[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (kind == KIND_TRUNC) begin
      n = $urandom_range(1, image_q.size());
      while (image_q.size() > n) void'(image_q.pop_back());
    end
  endfunction

  function automatic int pick_kind();
    int k;
    k = $urandom_range(0, 19);
    return (k < KIND_CLEAN) ? k : KIND_CLEAN;
  endfunction

  // Offers one byte transaction and waits until it is taken; called at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      byte_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    byte_valid          = 1'b1;
    byte_item.data_byte = b;
    byte_item.last_byte = lst;
    do @(posedge clk); while (!byte_ready);
    sb.note_byte(byte_item);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_image();
    foreach (image_q[i]) send_byte(image_q[i], i == image_q.size() - 1);
  endtask

  // Stops sending until every predicted result has been seen, then lets the pipe settle.
  task automatic wait_drained();
    byte_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Main stimulus sequence.
  initial begin
    int phase;
    rst           = 1'b1;
    byte_valid    = 1'b0;
    byte_item     = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    items_sent    = 0;
    hold_requests = 0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a one-byte image, then a clean header with no payload.
    write_reg(ahv_pkg::REG_ICON_COUNT, '0);
    send_byte(8'hFF, 1'b1);
    build_image(KIND_CLEAN);
    send_image();
    wait_drained();

    // Random phases, each under its own register setting.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      tx_idle_on = (items_sent < TAIL_START) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (items_sent < TAIL_START) && ($urandom_range(0, 3) != 0);
      configure_phase(phase);
      repeat ($urandom_range(2, 6)) begin
        build_image(pick_kind());
        send_image();
      end
      // Back pressure: the receiver stops while one-byte images keep arriving.
      if (phase == PRESSURE_PHASE) begin
        hold_requests++;
        repeat (12) send_byte(8'($urandom), 1'b1);
      end
      wait_drained();
      phase++;
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
